// ===== hw/rtl/jdc_pkg.sv =====
// Shared types and constants for the Julian day number calendar converter.
// Holds the pipeline item record and the month offset table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jdc_pkg;

   localparam int NUM_STAGES = 8;

   localparam logic        OP_TO_JD   = 1'b0;
   localparam logic        OP_FROM_JD = 1'b1;

   localparam logic [13:0] YEAR_MIN    = 14'd1;
   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [13:0] REFORM_YEAR = 14'd1582;
   localparam logic [3:0]  REFORM_MON  = 4'd10;
   localparam logic [4:0]  GAP_FIRST   = 5'd5;
   localparam logic [4:0]  GAP_LAST    = 5'd14;
   localparam logic [4:0]  GREG_FIRST  = 5'd15;

   localparam logic [22:0] JD_MIN        = 23'd1721424;
   localparam logic [22:0] JD_MAX        = 23'd5373484;
   localparam logic [22:0] JD_GREG_START = 23'd2299160;

   localparam logic [14:0] YEAR_BIAS    = 15'd4716;
   localparam logic [14:0] YEAR_BIAS_JF = 15'd4715;
   localparam logic [10:0] DAYS_4YEARS  = 11'd1461;
   localparam logic [10:0] JD_OFFSET    = 11'd1524;
   localparam logic [24:0] B_OFFSET     = 25'd7468865;
   localparam logic [11:0] E_OFFSET     = 12'd2442;

   // floor(y / 100) = (y * DIV100_MULT) >> DIV100_SHIFT for 14-bit y
   localparam logic [12:0] DIV100_MULT  = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   // floor(n / 146097) for n below 2**24
   localparam logic [24:0] B_MULT       = 25'd30103606;
   localparam int          B_SHIFT      = 42;
   // floor(n / 7305) for n below 2**27
   localparam logic [27:0] E_MULT       = 28'd150514939;
   localparam int          E_SHIFT      = 40;

   typedef struct packed {
      logic        op;
      logic [4:0]  d;
      logic [3:0]  m;
      logic [13:0] y;
      logic [13:0] yy;
      logic [3:0]  mm;
      logic        date_ok;
      logic        greg;
      logic [7:0]  qy;
      logic [7:0]  qa;
      logic [24:0] t1;
      logic [8:0]  ka;
      logic [22:0] jd;
      logic [2:0]  wday;
      logic [22:0] a;
      logic        rerr;
      logic        gb;
      logic [23:0] nb;
      logic [48:0] pb;
      logic [22:0] dd;
      logic [26:0] ne;
      logic [54:0] pe;
      logic [14:0] e;
      logic [9:0]  r;
      logic [3:0]  g;
      logic [4:0]  out_d;
      logic [3:0]  out_m;
      logic [13:0] out_y;
   } pipe_type;

   // floor(30.6001 * k)
   function automatic logic [8:0] month_offset(input logic [3:0] k);
      logic [8:0] v;
      case (k)
         4'd1:    v = 9'd30;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd91;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd183;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd244;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd336;
         4'd12:   v = 9'd367;
         4'd13:   v = 9'd397;
         4'd14:   v = 9'd428;
         4'd15:   v = 9'd459;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/julian_day_calendar_converter.sv =====
// Top level of the Julian day number calendar converter: handshakes and stage valids.
// Depends on jdc_pkg and jdc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Converts a calendar date to its Julian day number and weekday (opcode 0), or a
// Julian day number back to a date (opcode 1), Julian calendar before 15 October
// 1582 and Gregorian from then on. The block is an 8-stage pipeline: an item
// accepted into stage 0 moves through stage registers 0 to 7, the last of which
// drives the rsp ports, and one item can be taken every cycle while rsp_stall is low.
// The stage count is set by the two wide reciprocal multiplies of the
// day number path (by 1/146097 and 1/7305), each in a stage of its own with the
// sums around them. Every stage has its own valid bit, so a stall on the result
// side only backs up into the input once all eight stages hold an item.

module julian_day_calendar_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_opcode,
   input  wire logic [4:0]  req_day,
   input  wire logic [3:0]  req_month,
   input  wire logic [13:0] req_year,
   input  wire logic [22:0] req_day_number,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_date_valid,
   output      logic [22:0] rsp_jd_out,
   output      logic [2:0]  rsp_weekday,
   output      logic [4:0]  rsp_out_day,
   output      logic [3:0]  rsp_out_month,
   output      logic [13:0] rsp_out_year,
   output      logic        rsp_range_error
);
   import jdc_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES:0]   rdy;
   pipe_type              last_item;

   // a stage takes a new item when empty or when the next one moves on
   always_comb begin
      rdy[NUM_STAGES] = !rsp_stall;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (!rdy[i]) begin
            vld_in[i] = vld_ff[i];
         end else if (i == 0) begin
            vld_in[i] = req_valid;
         end else begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   jdc_datapath u_datapath (
      .clock          (clock),
      .ld             (rdy[NUM_STAGES-1:0]),
      .req_opcode     (req_opcode),
      .req_day        (req_day),
      .req_month      (req_month),
      .req_year       (req_year),
      .req_day_number (req_day_number),
      .rsp_item       (last_item)
   );

   assign req_stall       = !rdy[0];
   assign rsp_valid       = vld_ff[NUM_STAGES-1];
   assign rsp_date_valid  = last_item.date_ok;
   assign rsp_jd_out      = last_item.jd;
   assign rsp_weekday     = last_item.wday;
   assign rsp_out_day     = last_item.out_d;
   assign rsp_out_month   = last_item.out_m;
   assign rsp_out_year    = last_item.out_y;
   assign rsp_range_error = last_item.rerr;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("input stalled while a pipeline stage is empty");

   a_invalid_date_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_date_valid) |-> (rsp_jd_out == 23'd0 && rsp_weekday == 3'd0))
      else $error("invalid date carries a day number or weekday");

   a_range_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |->
      (rsp_out_day == 5'd0 && rsp_out_month == 4'd0 && rsp_out_year == 14'd0 &&
       !rsp_date_valid))
      else $error("range error item carries date fields");

   a_weekday_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday <= 3'd6))
      else $error("weekday fold out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/jdc_datapath.sv =====
// Eight-stage datapath of the calendar converter: both conversions side by side.
// Depends on jdc_pkg; stage load enables come from the top level.
`timescale 1ns / 1ps
`default_nettype none

module jdc_datapath (
   input  wire logic                             clock,
   input  wire logic [jdc_pkg::NUM_STAGES-1:0]   ld,
   input  wire logic                             req_opcode,
   input  wire logic [4:0]                       req_day,
   input  wire logic [3:0]                       req_month,
   input  wire logic [13:0]                      req_year,
   input  wire logic [22:0]                      req_day_number,
   output jdc_pkg::pipe_type                     rsp_item
);
   import jdc_pkg::*;

   pipe_type st_ff [NUM_STAGES];
   pipe_type st_in [NUM_STAGES];

   logic        s0_shift;
   logic        s0_gap;
   logic [26:0] s1_prod_qy;
   logic [26:0] s1_prod_qa;
   logic [14:0] s1_ybias;
   logic [13:0] s2_r100;
   logic        s2_div4;
   logic        s2_leap;
   logic [4:0]  s2_mlen;
   logic [24:0] s2_jd;
   logic [6:0]  s2_b;
   logic [23:0] s3_x;
   logic [5:0]  s3_dsum;
   logic [3:0]  s3_t;
   logic [3:0]  s3_u;
   logic [25:0] s5_f;
   logic [3:0]  s6_cnt;
   logic [3:0]  s7_mon;

   // stage 0: capture, shift Jan/Feb to the previous year, range checks
   always_comb begin
      st_in[0]       = '0;
      s0_shift       = req_month < 4'd3;
      s0_gap         = (req_year == REFORM_YEAR) && (req_month == REFORM_MON) &&
                       (req_day >= GAP_FIRST) && (req_day <= GAP_LAST);
      st_in[0].op    = req_opcode;
      st_in[0].d     = req_day;
      st_in[0].m     = req_month;
      st_in[0].y     = req_year;
      st_in[0].yy    = s0_shift ? req_year - 14'd1 : req_year;
      st_in[0].mm    = s0_shift ? req_month + 4'd12 : req_month;
      st_in[0].date_ok = (req_year >= YEAR_MIN) && (req_year <= YEAR_MAX) &&
                         (req_month >= 4'd1) && (req_month <= 4'd12) &&
                         (req_day != 5'd0) && !s0_gap;
      st_in[0].greg  = (st_in[0].yy > REFORM_YEAR) ||
                       ((st_in[0].yy == REFORM_YEAR) &&
                        ((st_in[0].mm > REFORM_MON) ||
                         ((st_in[0].mm == REFORM_MON) && (req_day >= GREG_FIRST))));
      st_in[0].a     = req_day_number;
      st_in[0].rerr  = (req_day_number < JD_MIN) || (req_day_number > JD_MAX);
      st_in[0].gb    = req_day_number > JD_GREG_START;
      st_in[0].nb    = 24'({req_day_number, 2'b00} - B_OFFSET);
   end

   // stage 1: constant multiplies and the month offset lookup
   always_comb begin
      st_in[1]      = st_ff[0];
      s1_prod_qy    = 27'(st_ff[0].y) * 27'(DIV100_MULT);
      s1_prod_qa    = 27'(st_ff[0].yy) * 27'(DIV100_MULT);
      s1_ybias      = 15'(st_ff[0].yy) + YEAR_BIAS;
      st_in[1].qy   = 8'(s1_prod_qy >> DIV100_SHIFT);
      st_in[1].qa   = 8'(s1_prod_qa >> DIV100_SHIFT);
      st_in[1].t1   = 25'(s1_ybias) * 25'(DAYS_4YEARS);
      st_in[1].ka   = month_offset(st_ff[0].mm + 4'd1) + 9'(st_ff[0].d);
      st_in[1].pb   = 49'(st_ff[0].nb) * 49'(B_MULT);
   end

   // stage 2: leap year and month length, day number sum, century correction
   always_comb begin
      st_in[2]  = st_ff[1];
      s2_r100   = st_ff[1].y - 14'(14'(st_ff[1].qy) * 14'd100);
      s2_div4   = st_ff[1].y[1:0] == 2'd0;
      if (st_ff[1].y < REFORM_YEAR) begin
         s2_leap = s2_div4;
      end else begin
         s2_leap = (s2_div4 && (s2_r100 != 14'd0)) ||
                   ((s2_r100 == 14'd0) && (st_ff[1].qy[1:0] == 2'd0));
      end
      case (st_ff[1].m)
         4'd2:    s2_mlen = s2_leap ? 5'd29 : 5'd28;
         4'd4:    s2_mlen = 5'd30;
         4'd6:    s2_mlen = 5'd30;
         4'd9:    s2_mlen = 5'd30;
         4'd11:   s2_mlen = 5'd30;
         default: s2_mlen = 5'd31;
      endcase
      st_in[2].date_ok = st_ff[1].date_ok && (st_ff[1].d <= s2_mlen);
      s2_jd = 25'(st_ff[1].t1 >> 2) + 25'(st_ff[1].ka) - 25'(JD_OFFSET);
      if (st_ff[1].greg) begin
         s2_jd = s2_jd + 25'd2 + 25'(st_ff[1].qa >> 2) - 25'(st_ff[1].qa);
      end
      st_in[2].jd = s2_jd[22:0];
      s2_b = 7'(st_ff[1].pb >> B_SHIFT);
      if (st_ff[1].gb) begin
         st_in[2].dd = st_ff[1].a + 23'(JD_OFFSET) + 23'd1 + 23'(s2_b) - 23'(s2_b >> 2);
      end else begin
         st_in[2].dd = st_ff[1].a + 23'(JD_OFFSET);
      end
   end

   // stage 3: weekday by octal digit folding (8 = 1 mod 7), 20*D - 2442
   always_comb begin
      st_in[3] = st_ff[2];
      s3_x     = 24'(st_ff[2].jd) + 24'd1;
      s3_dsum  = '0;
      for (int i = 0; i < 8; i++) begin
         s3_dsum = s3_dsum + 6'(s3_x[3*i +: 3]);
      end
      s3_t = 4'(s3_dsum[5:3]) + 4'(s3_dsum[2:0]);
      s3_u = 4'(s3_t[3]) + 4'(s3_t[2:0]);
      st_in[3].wday = (s3_u >= 4'd7) ? 3'(s3_u - 4'd7) : 3'(s3_u);
      st_in[3].ne   = 27'({st_ff[2].dd, 4'b0000}) + 27'({st_ff[2].dd, 2'b00}) -
                      27'(E_OFFSET);
   end

   // stage 4: reciprocal multiply for the year count
   always_comb begin
      st_in[4]    = st_ff[3];
      st_in[4].pe = 55'(st_ff[3].ne) * 55'(E_MULT);
   end

   // stage 5: year count, days before it, remainder
   always_comb begin
      st_in[5]   = st_ff[4];
      st_in[5].e = 15'(st_ff[4].pe >> E_SHIFT);
      s5_f       = 26'(st_in[5].e) * 26'(DAYS_4YEARS);
      st_in[5].r = 10'(st_ff[4].dd - 23'(s5_f >> 2));
   end

   // stage 6: month count by comparison against the offset table
   always_comb begin
      st_in[6] = st_ff[5];
      s6_cnt   = '0;
      for (int k = 1; k < 16; k++) begin
         s6_cnt = s6_cnt + 4'(10'(month_offset(4'(k))) < st_ff[5].r);
      end
      st_in[6].g = s6_cnt;
   end

   // stage 7: day, month, year; drop fields that the opcode does not own
   always_comb begin
      st_in[7] = st_ff[6];
      s7_mon   = (st_ff[6].g < 4'd14) ? st_ff[6].g - 4'd1 : st_ff[6].g - 4'd13;
      st_in[7].out_d = 5'(st_ff[6].r - 10'(month_offset(st_ff[6].g)));
      st_in[7].out_m = s7_mon;
      st_in[7].out_y = (s7_mon > 4'd2) ? 14'(st_ff[6].e - YEAR_BIAS) :
                                         14'(st_ff[6].e - YEAR_BIAS_JF);
      if (st_ff[6].op == OP_TO_JD) begin
         st_in[7].rerr  = 1'b0;
         st_in[7].out_d = '0;
         st_in[7].out_m = '0;
         st_in[7].out_y = '0;
         if (!st_ff[6].date_ok) begin
            st_in[7].jd   = '0;
            st_in[7].wday = '0;
         end
      end else begin
         st_in[7].date_ok = 1'b0;
         st_in[7].jd      = '0;
         st_in[7].wday    = '0;
         if (st_ff[6].rerr) begin
            st_in[7].out_d = '0;
            st_in[7].out_m = '0;
            st_in[7].out_y = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (ld[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign rsp_item = st_ff[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== bench/jdc_result_checker.sv =====
// Result checker for the Julian day calendar converter: predicts each result from the
// accepted input item and compares it field by field with what the block returns.
// Depends on jdc_pkg for the opcode constants.
`timescale 1ns / 1ps

module jdc_result_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_opcode,
   input  wire logic [4:0]  req_day,
   input  wire logic [3:0]  req_month,
   input  wire logic [13:0] req_year,
   input  wire logic [22:0] req_day_number,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_date_valid,
   input  wire logic [22:0] rsp_jd_out,
   input  wire logic [2:0]  rsp_weekday,
   input  wire logic [4:0]  rsp_out_day,
   input  wire logic [3:0]  rsp_out_month,
   input  wire logic [13:0] rsp_out_year,
   input  wire logic        rsp_range_error,
   output int               fail_count,
   output int               pending,
   output int               checked
);

   import jdc_pkg::*;

   typedef struct packed {
      logic        date_valid;
      logic [22:0] jd_out;
      logic [2:0]  weekday;
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [13:0] out_year;
      logic        range_error;
   } calendar_result_type;

   calendar_result_type expected_q[$];
   int errors = 0;
   int compared = 0;

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
   end

   function automatic bit is_leap(longint y);
      if (y < 1582)
         return (y % 4) == 0;
      return (y % 400) == 0 || ((y % 4) == 0 && (y % 100) != 0);
   endfunction

   function automatic longint days_in_month(longint m, longint y);
      if (m == 2)
         return is_leap(y) ? 29 : 28;
      if (m <= 7)
         return (m % 2) ? 31 : 30;
      return (m % 2) ? 30 : 31;
   endfunction

   function automatic calendar_result_type convert_item(logic op, longint d, longint m,
                                                         longint y, longint n);
      calendar_result_type r;
      longint yy, mm, corr, jd, b, base, dd, e, f, g, h, mon, yr;
      r = '0;
      if (op == OP_TO_JD) begin
         if (y >= 1 && y <= 9999 && m >= 1 && m <= 12 && d >= 1
             && d <= days_in_month(m, y)
             && !(y == 1582 && m == 10 && d >= 5 && d <= 14)) begin
            yy = y;
            mm = m;
            corr = 0;
            if (mm < 3) begin
               yy = yy - 1;
               mm = mm + 12;
            end
            if (yy > 1582 || (yy == 1582 && (mm > 10 || (mm == 10 && d >= 15))))
               corr = 2 - yy / 100 + (yy / 100) / 4;
            jd = (1461 * (yy + 4716)) / 4 + (306001 * (mm + 1)) / 10000 + d + corr - 1524;
            r.date_valid = 1'b1;
            r.jd_out = jd[22:0];
            r.weekday = 3'((jd + 1) % 7);
         end
      end else if (n < 1721424 || n > 5373484) begin
         r.range_error = 1'b1;
      end else begin
         if (n > 2299160) begin
            b = (4 * n - 7468865) / 146097;
            base = n + 1 + b - b / 4;
         end else begin
            base = n;
         end
         dd = base + 1524;
         e = (20 * dd - 2442) / 7305;
         f = (1461 * e) / 4;
         g = ((dd - f) * 10000) / 306001;
         h = dd - f - (g * 306001) / 10000;
         mon = (g < 14) ? g - 1 : g - 13;
         yr = (mon > 2) ? e - 4716 : e - 4715;
         r.out_day = h[4:0];
         r.out_month = mon[3:0];
         r.out_year = yr[13:0];
      end
      return r;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      calendar_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_q = {expected_q, convert_item(req_opcode, req_day, req_month,
                                                   req_year, req_day_number)};
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result returned with no item outstanding");
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("date_valid", want.date_valid, rsp_date_valid);
               check_field("jd_out", want.jd_out, rsp_jd_out);
               check_field("weekday", want.weekday, rsp_weekday);
               check_field("out_day", want.out_day, rsp_out_day);
               check_field("out_month", want.out_month, rsp_out_month);
               check_field("out_year", want.out_year, rsp_out_year);
               check_field("range_error", want.range_error, rsp_range_error);
               compared++;
            end
         end
      end
      fail_count <= errors;
      pending <= expected_q.size();
      checked <= compared;
   end

endmodule

// ===== bench/julian_day_calendar_converter_test.sv =====
// Testbench top for the Julian day calendar converter: clock, reset, directed and
// random item stimulus, random stalls, watchdog and verdict.
// Depends on jdc_pkg, julian_day_calendar_converter and jdc_result_checker.
`timescale 1ns / 1ps

module julian_day_calendar_converter_test;

   import jdc_pkg::*;

   localparam int RANDOM_ITEMS = 1130;
   localparam int DEAD_LIMIT = 4000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_TO_JD;
   logic [4:0]  req_day = '0;
   logic [3:0]  req_month = '0;
   logic [13:0] req_year = '0;
   logic [22:0] req_day_number = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_date_valid;
   logic [22:0] rsp_jd_out;
   logic [2:0]  rsp_weekday;
   logic [4:0]  rsp_out_day;
   logic [3:0]  rsp_out_month;
   logic [13:0] rsp_out_year;
   logic        rsp_range_error;

   int fail_count;
   int pending;
   int checked;
   int dead_cycles = 0;
   int to_jd_sent = 0;
   int from_jd_sent = 0;
   bit no_idling = 1'b0;
   bit squeeze = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   julian_day_calendar_converter dut (.*);

   jdc_result_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         dead_cycles <= 0;
      end else if (dead_cycles >= DEAD_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         dead_cycles <= dead_cycles + 1;
      end
   end

   // Receiver: random stalls, or one long hold-off when asked.
   initial begin
      int hold_left;
      hold_left = 0;
      while (reset)
         @(posedge clock);
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            hold_left = 96;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idling && ($urandom_range(99) < 29);
         end
         @(posedge clock);
      end
   end

   task automatic send_item(input logic op, input logic [4:0] d, input logic [3:0] m,
                            input logic [13:0] y, input logic [22:0] n);
      while (!no_idling && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_day <= d;
      req_month <= m;
      req_year <= y;
      req_day_number <= n;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (op == OP_TO_JD)
         to_jd_sent++;
      else
         from_jd_sent++;
   endtask

   initial begin
      logic [4:0]  d;
      logic [3:0]  m;
      logic [13:0] y;
      logic [22:0] n;
      int          pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // date to day number: limits, calendar switch, leap rules, bad fields
      send_item(OP_TO_JD, 5'd1, 4'd1, 14'd1, 23'($urandom));
      send_item(OP_TO_JD, 5'd31, 4'd12, 14'd9999, 23'($urandom));
      send_item(OP_TO_JD, 5'd4, 4'd10, 14'd1582, 23'($urandom));
      send_item(OP_TO_JD, 5'd15, 4'd10, 14'd1582, 23'($urandom));
      send_item(OP_TO_JD, 5'd5, 4'd10, 14'd1582, 23'($urandom));
      send_item(OP_TO_JD, 5'd14, 4'd10, 14'd1582, 23'($urandom));
      send_item(OP_TO_JD, 5'd29, 4'd2, 14'd1500, 23'($urandom));
      send_item(OP_TO_JD, 5'd29, 4'd2, 14'd1700, 23'($urandom));
      send_item(OP_TO_JD, 5'd29, 4'd2, 14'd2000, 23'($urandom));
      send_item(OP_TO_JD, 5'd0, 4'd5, 14'd2020, 23'($urandom));
      send_item(OP_TO_JD, 5'd31, 4'd4, 14'd2021, 23'($urandom));
      send_item(OP_TO_JD, 5'd1, 4'd0, 14'd2000, 23'($urandom));
      send_item(OP_TO_JD, 5'd1, 4'd13, 14'd2000, 23'($urandom));
      send_item(OP_TO_JD, 5'd31, 4'd15, 14'd16383, 23'h7FFFFF);
      send_item(OP_TO_JD, 5'd1, 4'd1, 14'd0, 23'($urandom));
      send_item(OP_TO_JD, 5'd1, 4'd1, 14'd10000, 23'($urandom));
      // day number to date: range edges, calendar switch, field extremes
      send_item(OP_FROM_JD, 5'd31, 4'd15, 14'd16383, 23'd1721424);
      send_item(OP_FROM_JD, 5'($urandom), 4'($urandom), 14'($urandom), 23'd1721423);
      send_item(OP_FROM_JD, 5'($urandom), 4'($urandom), 14'($urandom), 23'd5373484);
      send_item(OP_FROM_JD, 5'($urandom), 4'($urandom), 14'($urandom), 23'd5373485);
      send_item(OP_FROM_JD, 5'($urandom), 4'($urandom), 14'($urandom), 23'd2299160);
      send_item(OP_FROM_JD, 5'($urandom), 4'($urandom), 14'($urandom), 23'd2299161);
      send_item(OP_FROM_JD, 5'd0, 4'd0, 14'd0, 23'd0);
      send_item(OP_FROM_JD, 5'($urandom), 4'($urandom), 14'($urandom), 23'h7FFFFF);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300)
            squeeze = 1'b1;
         no_idling = (i >= 600 && i < 800);
         d = 5'($urandom);
         m = 4'($urandom);
         y = 14'($urandom);
         n = 23'($urandom);
         pick = $urandom_range(99);
         if (pick < 40) begin
            case ($urandom_range(9))
               0:       y = 14'($urandom_range(1575, 1590));
               1:       y = $urandom_range(1) ? 14'($urandom_range(1, 4))
                                              : 14'($urandom_range(9996, 9999));
               default: y = 14'($urandom_range(1, 9999));
            endcase
            m = 4'($urandom_range(1, 12));
            if (y == 14'd1582 && $urandom_range(1))
               m = 4'd10;
            d = 5'($urandom_range(1, ($urandom_range(3) == 0) ? 31 : 28));
            send_item(OP_TO_JD, d, m, y, n);
         end else if (pick < 50) begin
            send_item(OP_TO_JD, d, m, y, n);
         end else if (pick < 85) begin
            case ($urandom_range(9))
               0:       n = 23'($urandom_range(2298760, 2299560));
               1:       n = 23'($urandom_range(1721424, 1722200));
               2:       n = 23'($urandom_range(5372700, 5373484));
               default: n = 23'($urandom_range(1721424, 5373484));
            endcase
            send_item(OP_FROM_JD, d, m, y, n);
         end else begin
            send_item(OP_FROM_JD, d, m, y, n);
         end
      end
      req_valid <= 1'b0;
      no_idling = 1'b0;
      @(posedge clock);

      while (pending != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Summary: %0d items (%0d date to day number, %0d day number to date),",
               to_jd_sent + from_jd_sent, to_jd_sent, from_jd_sent);
      $display("         %0d results compared under random and long output stalls",
               checked);
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/jdc_pkg.sv
hw/rtl/jdc_datapath.sv
hw/rtl/julian_day_calendar_converter.sv
bench/jdc_result_checker.sv
bench/julian_day_calendar_converter_test.sv
